// ----- sv/bfrx_pkg.sv -----
package bfrx_pkg;

   // Framing bytes
   localparam logic [7:0] BYTE_BEGIN  = 8'hff;
   localparam logic [7:0] BYTE_END    = 8'hfe;
   localparam logic [7:0] BYTE_ACK    = 8'hfd;
   localparam logic [7:0] BYTE_ERR    = 8'hfc;
   localparam logic [7:0] BYTE_CMDMIN = 8'hf0;

   // Register reset values
   localparam logic [7:0] ESCAPE_RESET = 8'd251;
   localparam logic [7:0] MAXLEN_RESET = 8'd240;

   // Register indexes
   localparam logic [0:0] CSR_ESCAPE = 1'b0;
   localparam logic [0:0] CSR_MAXLEN = 1'b1;

   // Event codes
   localparam logic [2:0] EV_DATA = 3'd0;
   localparam logic [2:0] EV_GOOD = 3'd1;
   localparam logic [2:0] EV_BAD  = 3'd2;
   localparam logic [2:0] EV_LONG = 3'd3;
   localparam logic [2:0] EV_PACK = 3'd4;
   localparam logic [2:0] EV_PERR = 3'd5;

   typedef enum logic [7:0] {
      PH_IDLE = 8'b0000_0001,
      PH_LEN  = 8'b0000_0010,
      PH_RID  = 8'b0000_0100,
      PH_XOR  = 8'b0000_1000,
      PH_REV  = 8'b0001_0000,
      PH_TRS  = 8'b0010_0000,
      PH_AOP  = 8'b0100_0000,
      PH_EOP  = 8'b1000_0000
   } phase_type;

endpackage

// ----- sv/byte_frame_receiver_xor_check_unit.sv -----
// Channel  | Dir | Payload (tdata, low bit first)         | Accepted when
// ---------+-----+----------------------------------------+---------------------------
// req_     | in  | [7:0] rx_byte                          | req_tvalid & req_tready
// rsp_     | out | [2:0] event_res, [10:3] value, pad 0s  | rsp_tvalid & rsp_tready
// csr_     | in  | csr_index (0 escape, 1 max length)     | csr_valid & csr_ready
//
// One beat per cycle sustained while rsp is not stalled. A beat is held in the
// input register, then the frame state machine decides on it and loads the result
// register; beats that make no result vanish. Reset (synchronous, active high)
// clears the frame state and loads register defaults. A stall on rsp backs up
// through the input register to req_tready; both registers keep their contents
// while stalled. csr_ready is always high.
module byte_frame_receiver_xor_check_unit
   import bfrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] event_res, [10:3] value, [15:11] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // configuration
   logic [7:0] escape_ff;
   logic [7:0] maxlen_ff;

   // input register
   logic       stage_valid_ff;
   logic [7:0] stage_byte_ff;

   // frame state
   phase_type         phase_ff, phase_in;
   logic signed [8:0] remaining_ff, remaining_in;
   logic [7:0]        frame_id_ff, frame_id_in;
   logic [7:0]        sent_xor_ff, sent_xor_in;
   logic [7:0]        running_xor_ff, running_xor_in;

   // result register
   logic       rsp_valid_ff;
   logic [2:0] rsp_event_ff;
   logic [7:0] rsp_value_ff;

   logic       advance;     // stage beat is consumed this cycle
   logic       emit;
   logic [2:0] emit_event;
   logic [7:0] emit_value;
   logic       do_count;
   logic [7:0] b;

   assign csr_ready  = 1'b1;
   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_value_ff, rsp_event_ff};
   assign b          = stage_byte_ff;

   // frame state machine
   always_comb begin
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      frame_id_in    = frame_id_ff;
      sent_xor_in    = sent_xor_ff;
      running_xor_in = running_xor_ff;
      emit           = 1'b0;
      emit_event     = EV_DATA;
      emit_value     = b;
      do_count       = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (b > BYTE_CMDMIN) begin
               if (b == BYTE_BEGIN)    phase_in = PH_LEN;
               else if (b == BYTE_ACK) phase_in = PH_AOP;
               else if (b == BYTE_ERR) phase_in = PH_EOP;
            end
         end
         PH_LEN: begin
            if (b <= maxlen_ff) begin
               remaining_in = {1'b0, b};
               phase_in     = PH_RID;
            end else begin
               // too long: answer with the id kept from an earlier frame
               phase_in   = PH_IDLE;
               emit       = 1'b1;
               emit_event = EV_LONG;
               emit_value = frame_id_ff;
            end
         end
         PH_RID: begin
            frame_id_in = b;
            phase_in    = PH_XOR;
         end
         PH_XOR: begin
            sent_xor_in    = b;
            running_xor_in = 8'h00;
            phase_in       = PH_REV;
         end
         PH_REV: begin
            // end byte wins over an escape of the same value
            if (b == BYTE_END) begin
               phase_in   = PH_IDLE;
               emit       = 1'b1;
               emit_event = ((running_xor_ff == sent_xor_ff) && (remaining_ff == 9'sd0))
                            ? EV_GOOD : EV_BAD;
               emit_value = frame_id_ff;
            end else if (b == escape_ff) begin
               do_count = 1'b1;
               phase_in = PH_TRS;
            end else begin
               do_count = 1'b1;
               emit     = 1'b1;
            end
         end
         PH_TRS: begin
            do_count = 1'b1;
            emit     = 1'b1;
            phase_in = PH_REV;
         end
         PH_AOP: begin
            phase_in   = PH_IDLE;
            emit       = 1'b1;
            emit_event = EV_PACK;
         end
         PH_EOP: begin
            phase_in   = PH_IDLE;
            emit       = 1'b1;
            emit_event = EV_PERR;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (do_count) begin
         // count floors at -1
         if (!remaining_ff[8]) remaining_in = remaining_ff - 9'sd1;
         running_xor_in = running_xor_ff ^ b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= ESCAPE_RESET;
         maxlen_ff <= MAXLEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ESCAPE: escape_ff <= csr_data;
            CSR_MAXLEN: maxlen_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         stage_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         remaining_ff   <= 9'sd0;
         frame_id_ff    <= 8'h00;
         sent_xor_ff    <= 8'h00;
         running_xor_ff <= 8'h00;
      end else if (advance) begin
         phase_ff       <= phase_in;
         remaining_ff   <= remaining_in;
         frame_id_ff    <= frame_id_in;
         sent_xor_ff    <= sent_xor_in;
         running_xor_ff <= running_xor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_event_ff <= emit_event;
         rsp_value_ff <= emit_value;
      end
   end

   // remaining only goes negative as far as -1
   a_floor: assert property (@(posedge clock) disable iff (reset)
      remaining_ff[8] |-> (remaining_ff == -9'sd1))
      else $error("remaining count below -1");

   // a result in the output register carries a defined event
   a_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_event_ff <= EV_PERR))
      else $error("undefined event code");

   // the byte after an escape always comes out as data
   a_trs: assert property (@(posedge clock) disable iff (reset)
      (advance && (phase_ff == PH_TRS)) |=>
         (rsp_valid_ff && (rsp_event_ff == EV_DATA) && (phase_ff == PH_REV)))
      else $error("escaped byte not passed as data");

   // an oversize length returns to idle with a length event
   a_long: assert property (@(posedge clock) disable iff (reset)
      (advance && (phase_ff == PH_LEN) && (stage_byte_ff > maxlen_ff)) |=>
         ((phase_ff == PH_IDLE) && rsp_valid_ff && (rsp_event_ff == EV_LONG)))
      else $error("oversize length not rejected");

endmodule
